// ===== rtl/fppf_pkg.sv =====
// Package: shared types and constants of the flash page program framer.
`default_nettype none

package fppf_pkg;

  // Serial NOR command opcodes
  localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] CMD_PAGE_PROGRAM = 8'h02;

  // Page size limits and reset value (log2 of bytes)
  localparam logic [3:0] PAGE_LOG2_MIN   = 4'd4;
  localparam logic [3:0] PAGE_LOG2_MAX   = 4'd12;
  localparam logic [3:0] PAGE_LOG2_RESET = 4'd8;
  localparam int unsigned PAGE_OFS_BITS  = 12;

  // Bits of the address that go on the wire
  localparam int unsigned WIRE_ADDR_BITS = 24;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  // Byte slot within one expanded item
  typedef enum logic [5:0] {
    PH_WREN     = 6'b000001,
    PH_PROG     = 6'b000010,
    PH_ADDR_HI  = 6'b000100,
    PH_ADDR_MID = 6'b001000,
    PH_ADDR_LO  = 6'b010000,
    PH_DATA     = 6'b100000
  } fppf_phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [23:0] start_address;
    logic        is_first;
    logic        is_last;
  } fppf_in_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       select_begin;
    logic       select_end;
    logic       poll_busy;
    logic       last_of_run;
  } fppf_out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [7:0]                data_byte;
    logic [WIRE_ADDR_BITS-1:0] address;
    logic                      open_seg;
    logic                      close_seg;
  } fppf_desc_t;

endpackage : fppf_pkg

`default_nettype wire

// ===== rtl/fppf_front.sv =====
// Front end: tracks the address and open transaction, classifies each byte.
`default_nettype none

module fppf_front
  import fppf_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  input  wire fppf_in_t   in_item,
  output fppf_desc_t      desc
);

  logic [3:0]              page_log2_r;
  logic [ADDRESS_BITS-1:0] next_addr_r, next_addr_nxt;
  logic                    in_frame_r, in_frame_nxt;

  logic [3:0]              lg;
  logic [PAGE_OFS_BITS-1:0] page_mask;
  logic [31:0]             start_wide;
  logic [ADDRESS_BITS-1:0] addr;
  logic [31:0]             addr_wide;
  logic                    close_seg;

  always_comb begin
    lg = page_log2_r;
    if (page_log2_r < PAGE_LOG2_MIN) begin
      lg = PAGE_LOG2_MIN;
    end else if (page_log2_r > PAGE_LOG2_MAX) begin
      lg = PAGE_LOG2_MAX;
    end
    page_mask  = PAGE_OFS_BITS'((13'd1 << lg) - 13'd1);
    start_wide = 32'(in_item.start_address);
    addr       = in_item.is_first ? start_wide[ADDRESS_BITS-1:0] : next_addr_r;
    addr_wide  = 32'(addr);
    close_seg  = in_item.is_last ||
                 ((addr_wide[PAGE_OFS_BITS-1:0] & page_mask) == page_mask);

    desc.data_byte = in_item.data_byte;
    desc.address   = addr_wide[WIRE_ADDR_BITS-1:0];
    desc.open_seg  = in_item.is_first || !in_frame_r;
    desc.close_seg = close_seg;

    next_addr_nxt = next_addr_r;
    in_frame_nxt  = in_frame_r;
    if (in_valid) begin
      next_addr_nxt = addr + ADDRESS_BITS'(1);
      in_frame_nxt  = !close_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_log2_r <= PAGE_LOG2_RESET;
      next_addr_r <= '0;
      in_frame_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_log2_r <= cfg_data;
      end
      next_addr_r <= next_addr_nxt;
      in_frame_r  <= in_frame_nxt;
    end
  end

endmodule : fppf_front

`default_nettype wire

// ===== rtl/fppf_queue.sv =====
// Short descriptor queue between the front and back ends.
`default_nettype none

module fppf_queue
  import fppf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire fppf_desc_t wr_desc,
  output logic            full,
  input  wire logic       rd_en,
  output fppf_desc_t      rd_desc,
  output logic            empty
);

  fppf_desc_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_BITS:0]   count_r, count_nxt;

  assign full    = (count_r == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_desc = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + (QUEUE_PTR_BITS+1)'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - (QUEUE_PTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_BITS'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule : fppf_queue

`default_nettype wire

// ===== rtl/fppf_back.sv =====
// Back end: expands each descriptor into SPI byte frames into an output register.
`default_nettype none

module fppf_back
  import fppf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire fppf_desc_t q_desc,
  output logic            q_rd,
  output logic            empty,
  input  wire logic       pop,
  output fppf_out_t       out_data
);

  fppf_phase_t phase_r, phase_nxt;
  fppf_phase_t ph;
  fppf_phase_t ph_succ;
  logic        out_valid_r, out_valid_nxt;
  fppf_out_t   out_r, out_nxt;
  logic        advance;
  logic        done;

  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_comb begin
    advance = !out_valid_r || pop;
    ph      = q_desc.open_seg ? phase_r : PH_DATA;
    done    = (ph == PH_DATA);

    out_nxt = '0;
    ph_succ = PH_WREN;
    case (ph)
      PH_WREN: begin
        out_nxt.spi_byte     = CMD_WRITE_ENABLE;
        out_nxt.select_begin = 1'b1;
        out_nxt.select_end   = 1'b1;
        ph_succ              = PH_PROG;
      end
      PH_PROG: begin
        out_nxt.spi_byte     = CMD_PAGE_PROGRAM;
        out_nxt.select_begin = 1'b1;
        ph_succ              = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        out_nxt.spi_byte = q_desc.address[23:16];
        ph_succ          = PH_ADDR_MID;
      end
      PH_ADDR_MID: begin
        out_nxt.spi_byte = q_desc.address[15:8];
        ph_succ          = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        out_nxt.spi_byte = q_desc.address[7:0];
        ph_succ          = PH_DATA;
      end
      PH_DATA: begin
        out_nxt.spi_byte    = q_desc.data_byte;
        out_nxt.select_end  = q_desc.close_seg;
        out_nxt.poll_busy   = q_desc.close_seg;
        out_nxt.last_of_run = 1'b1;
        ph_succ             = PH_WREN;
      end
      default: begin
        out_nxt = '0;
        ph_succ = PH_WREN;
      end
    endcase

    q_rd          = advance && !q_empty && done;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        phase_nxt = ph_succ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WREN;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule : fppf_back

`default_nettype wire

// ===== rtl/flash_page_program_framer.sv =====
// Top level of the serial NOR flash page program framer.
// Usage:
//   Input queue (push/full, in_data): one byte to program per transfer. The
//   first byte of a request carries start_address with is_first set; the
//   final byte has is_last set. A byte without is_first while no program
//   transaction is open reopens one at the address where the stream stopped.
//   Result queue (empty/pop, out_data): SPI byte frames with chip-select
//   begin/end marks and a busy-poll request on each closing data byte.
//   Config (cfg_we, cfg_data): log2 of the page size, write only while idle.
// Path: an accepted byte goes through the queue, then the output register.
// Throughput: one input transfer per cycle while bytes continue an open
//   transaction and the queue has room. A byte that opens a page segment
//   expands to six results, which the single output register emits one per
//   cycle while pop keeps up. A four-entry queue lets the front keep
//   accepting while the back expands a header.
// Reset: page size 256 bytes, address 0, no open transaction, queues empty.
// Stall: when pop is held low the output register holds its result, the
//   queue fills and full rises; nothing is dropped.
`default_nettype none

module flash_page_program_framer
  import fppf_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       push,
  output logic            full,
  input  wire fppf_in_t   in_data,
  output logic            empty,
  input  wire logic       pop,
  output fppf_out_t       out_data
);

  fppf_desc_t front_desc;
  fppf_desc_t head_desc;
  logic       in_accept;
  logic       q_empty;
  logic       q_rd;

  // Accept an input transfer whenever the queue has room
  assign in_accept = push && !full;

  fppf_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_accept),
    .in_item (in_data),
    .desc    (front_desc)
  );

  // Decouple classification from frame expansion
  fppf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_accept),
    .wr_desc(front_desc),
    .full   (full),
    .rd_en  (q_rd),
    .rd_desc(head_desc),
    .empty  (q_empty)
  );

  // Expand each descriptor into one or six frames
  fppf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_desc  (head_desc),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

endmodule : flash_page_program_framer

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the flash page program framer: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module testbench;
  import fppf_pkg::*;

  // Predict the SPI frames of each accepted byte and check them in order.
  class frame_scoreboard;
    logic [3:0]  page_log2;
    logic [23:0] next_addr;
    logic        in_frame;
    fppf_out_t   expected_frames[$];
    int          errors;

    function new();
      page_log2 = PAGE_LOG2_RESET;
      next_addr = '0;
      in_frame  = 1'b0;
      errors    = 0;
    endfunction

    function void set_page_log2(logic [3:0] value);
      page_log2 = value;
    endfunction

    // Clamp the register to the legal page sizes.
    function int page_bits();
      if (page_log2 < PAGE_LOG2_MIN) return PAGE_LOG2_MIN;
      if (page_log2 > PAGE_LOG2_MAX) return PAGE_LOG2_MAX;
      return page_log2;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function void add_frame(logic [7:0] b, logic sb, logic se, logic pb, logic lr);
      fppf_out_t f;
      f.spi_byte     = b;
      f.select_begin = sb;
      f.select_end   = se;
      f.poll_busy    = pb;
      f.last_of_run  = lr;
      expected_frames.push_back(f);
    endfunction

    function void note_input(fppf_in_t item);
      logic [12:0] page_mask;
      logic [23:0] addr;
      logic        close;
      page_mask = (13'd1 << page_bits()) - 13'd1;
      // A first byte abandons any open transaction.
      if (item.is_first) begin
        next_addr = item.start_address;
        in_frame  = 1'b0;
      end
      addr = next_addr;
      if (!in_frame) begin
        add_frame(CMD_WRITE_ENABLE, 1'b1, 1'b1, 1'b0, 1'b0);
        add_frame(CMD_PAGE_PROGRAM, 1'b1, 1'b0, 1'b0, 1'b0);
        add_frame(addr[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
        add_frame(addr[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
        add_frame(addr[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
      end
      close = item.is_last || ((addr[11:0] & page_mask[11:0]) == page_mask[11:0]);
      add_frame(item.data_byte, 1'b0, close, close, 1'b1);
      in_frame  = !close;
      next_addr = addr + 24'd1;
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(fppf_out_t got);
      fppf_out_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("unexpected frame %h", got));
        return;
      end
      want = expected_frames.pop_front();
      if (got.spi_byte !== want.spi_byte || got.select_begin !== want.select_begin ||
          got.select_end !== want.select_end || got.poll_busy !== want.poll_busy ||
          got.last_of_run !== want.last_of_run)
        report($sformatf("byte %h/%h begin %b/%b end %b/%b poll %b/%b last %b/%b (got/want)",
                         got.spi_byte, want.spi_byte, got.select_begin, want.select_begin,
                         got.select_end, want.select_end, got.poll_busy, want.poll_busy,
                         got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;
  logic       push = 1'b0;
  logic       full;
  fppf_in_t   in_data = '0;
  logic       empty;
  logic       pop = 1'b0;
  fppf_out_t  out_data;

  frame_scoreboard sb = new();

  // Idle percentages per side; the main sequence changes them per phase.
  int send_idle_pct = 16;
  int recv_idle_pct = 81;
  // Ask the receiver for a long hold-off; it counts the cycles itself.
  bit hold_req = 1'b0;
  int hold_left = 0;

  flash_page_program_framer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: decide pop at the falling edge, check the transfer at the rising edge.
  always begin
    @(negedge clk);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
    @(posedge clk);
    if (rst_n && pop && !empty) sb.check_result(out_data);
  end

  // Offer one item, idling first at random; return once the transfer happened.
  // Starts and ends at a falling edge.
  task automatic push_item(input fppf_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (full);
    sb.note_input(item);
    @(negedge clk);
  endtask

  task automatic push_fields(input logic [7:0] b, input logic [23:0] a,
                             input logic f, input logic l);
    fppf_in_t item;
    item.data_byte     = b;
    item.start_address = a;
    item.is_first      = f;
    item.is_last       = l;
    push_item(item);
  endtask

  // Wait until every expected frame has come out, then let the pipe settle.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the page size register; only called while the block is idle.
  task automatic write_page_log2(input logic [3:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_page_log2(value);
    @(negedge clk);
  endtask

  // Pick a start address: fully random, just short of a page end, or near the top.
  function automatic logic [23:0] pick_address();
    logic [23:0] mask;
    logic [23:0] a;
    mask = (24'd1 << sb.page_bits()) - 24'd1;
    a    = 24'($urandom);
    case ($urandom_range(2))
      0: pick_address = a;
      1: pick_address = (a | mask) - 24'($urandom_range(0, 6));
      default: pick_address = 24'hFFFFFF - 24'($urandom_range(0, 10));
    endcase
  endfunction

  // Mostly well-formed requests with random content, plus noise and broken requests.
  task automatic send_requests(input int n_items);
    int sent;
    int len;
    int kind;
    logic [23:0] a;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        len = $urandom_range(1, 12);
        a   = pick_address();
        for (int k = 0; k < len; k++) begin
          push_fields(8'($urandom), (k == 0) ? a : 24'($urandom), k == 0, k == len - 1);
        end
        sent += len;
      end else if (kind == 7) begin
        // Broken request: no last byte, so the next first byte abandons it.
        len = $urandom_range(1, 5);
        a   = pick_address();
        for (int k = 0; k < len; k++) begin
          push_fields(8'($urandom), (k == 0) ? a : 24'($urandom), k == 0, 1'b0);
        end
        sent += len;
      end else begin
        push_fields(8'($urandom), 24'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [3:0] page_settings[6];
    page_settings = '{4'd4, 4'd12, 4'd0, 4'd15, 4'd9, 4'($urandom_range(15))};

    // Hold reset at the start, then release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset page size of 256 bytes.
    // Open a segment two bytes before a page end; the next byte closes at the boundary.
    push_fields(8'h00, 24'h0000FE, 1'b1, 1'b0);
    push_fields(8'hFF, 24'hFFFFFF, 1'b0, 1'b0);
    // Continue with no first byte: reopen at the next page, ignore start_address.
    push_fields(8'hA5, 24'hFFFFFF, 1'b0, 1'b0);
    push_fields(8'h5A, 24'h000000, 1'b0, 1'b1);
    // Continue after a closed request: reopen where the stream stopped.
    push_fields(8'h3C, 24'h123456, 1'b0, 1'b0);
    // First byte while a transaction is open: abandon it, restart near the top.
    push_fields(8'h11, 24'hFFFFFE, 1'b1, 1'b0);
    push_fields(8'h22, 24'h000000, 1'b0, 1'b0);
    // Wrap past the top of the address space to 0.
    push_fields(8'h33, 24'h000000, 1'b0, 1'b0);
    push_fields(8'h44, 24'h000000, 1'b0, 1'b1);
    // Single-byte requests with first and last together, at the field extremes.
    push_fields(8'hFF, 24'hABCDEF, 1'b1, 1'b1);
    push_fields(8'h00, 24'hFFFFFF, 1'b1, 1'b1);
    push_fields(8'h80, 24'h000000, 1'b1, 1'b1);
    // Mid-page request of several bytes.
    push_fields(8'h01, 24'h555540, 1'b1, 1'b0);
    push_fields(8'h02, 24'hAAAAAA, 1'b0, 1'b0);
    push_fields(8'h7F, 24'h555555, 1'b0, 1'b1);
    drain();

    // Random phases, each at its own page size and idle pattern.
    for (int ph = 0; ph < 6; ph++) begin
      write_page_log2(page_settings[ph]);
      if (ph < 2) begin
        send_idle_pct = 16;
        recv_idle_pct = 81;
      end else if (ph < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Stall the output long enough to fill the queue and raise full.
      if (ph == 4) hold_req = 1'b1;
      send_requests(12);
      drain();
    end

    repeat (10) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d frames never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
